### hw/rtl/zsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsw_pkg
// Shared constants, types and codes of the running z-score block.
// ----------------------------------------------------------------------------
package zsw_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int MEAN_EXTRA  = 16;
    localparam int MEAN_WIDTH  = 48;
    localparam int M2_WIDTH    = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int OPND_WIDTH  = 64;
    localparam int MUL_WIDTH   = 50;
    localparam int ACC_WIDTH   = OPND_WIDTH + 2;
    localparam int DIV_STEPS   = OPND_WIDTH;
    localparam int SQRT_STEPS  = OPND_WIDTH / 2;
    localparam int MUL_STEPS   = MUL_WIDTH;
    localparam int STEP_WIDTH  = $clog2(OPND_WIDTH + 1);

    typedef enum logic [1:0] {
        OP_DIV,
        OP_MUL,
        OP_SQRT
    } t_unit_op;

    typedef struct packed {
        logic     start;
        t_unit_op op;
    } t_unit_req;

endpackage

### hw/rtl/zsw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsw_sample_if / zsw_result_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface zsw_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink (input valid, input sample_value, output ready);
endinterface

interface zsw_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] z_score;
    logic [31:0]        deviation;
    logic signed [31:0] mean_value;
    logic [31:0]        sample_total;

    modport source (output valid, output z_score, output deviation, output mean_value,
                    output sample_total, input ready);
    modport sink (input valid, input z_score, input deviation, input mean_value,
                  input sample_total, output ready);
endinterface

### hw/rtl/zsw_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsw_unit
// Shared iterative unit: restoring divide, shift-add multiply and
// digit-by-digit square root, all on one subtract/add datapath.
// ----------------------------------------------------------------------------
module zsw_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  zsw_pkg::t_unit_req              i_req,
    input  logic [zsw_pkg::OPND_WIDTH-1:0]  i_opa,
    input  logic [zsw_pkg::OPND_WIDTH-1:0]  i_opb,
    output logic                            o_done,
    output logic [zsw_pkg::OPND_WIDTH-1:0]  o_quotient,
    output logic [zsw_pkg::OPND_WIDTH/2-1:0] o_root,
    output logic [2*zsw_pkg::MUL_WIDTH-1:0] o_product
);
    import zsw_pkg::*;

    logic                        r_busy;
    logic                        r_done;
    t_unit_op                    r_op;
    logic [STEP_WIDTH-1:0]       r_step;
    logic [ACC_WIDTH-1:0]        r_acc;
    logic [OPND_WIDTH-1:0]       r_sh;
    logic [OPND_WIDTH-1:0]       r_opb;
    logic [OPND_WIDTH/2-1:0]     r_root;

    logic [ACC_WIDTH-1:0]        n_x;
    logic [ACC_WIDTH-1:0]        n_y;
    logic                        n_sub;
    logic [ACC_WIDTH:0]          n_res;
    logic [STEP_WIDTH-1:0]       n_last;

    always_comb begin
        n_x   = '0;
        n_y   = '0;
        n_sub = 1'b1;
        case (r_op)
            OP_DIV: begin
                n_x = {1'b0, r_acc[OPND_WIDTH-1:0], r_sh[OPND_WIDTH-1]};
                n_y = {2'b00, r_opb};
            end
            OP_SQRT: begin
                n_x = {r_acc[OPND_WIDTH-1:0], r_sh[OPND_WIDTH-1 -: 2]};
                n_y = ACC_WIDTH'({r_root, 2'b01});
            end
            OP_MUL: begin
                n_sub = 1'b0;
                n_x   = r_acc;
                n_y   = r_sh[0] ? ACC_WIDTH'(r_opb[MUL_WIDTH-1:0]) : '0;
            end
            default: begin
                n_sub = 1'b1;
            end
        endcase
        n_res = {1'b0, n_x} + {1'b0, (n_sub ? ~n_y : n_y)} + (ACC_WIDTH + 1)'(n_sub);
        case (r_op)
            OP_DIV:  n_last = STEP_WIDTH'(DIV_STEPS - 1);
            OP_SQRT: n_last = STEP_WIDTH'(SQRT_STEPS - 1);
            OP_MUL:  n_last = STEP_WIDTH'(MUL_STEPS - 1);
            default: n_last = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_DIV;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_step <= '0;
                r_root <= '0;
                r_acc  <= '0;
                if (i_req.op == OP_MUL) begin
                    r_sh  <= i_opb;
                    r_opb <= i_opa;
                end else begin
                    r_sh  <= i_opa;
                    r_opb <= i_opb;
                end
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == n_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                case (r_op)
                    OP_DIV: begin
                        r_acc <= n_res[ACC_WIDTH] ? {2'b00, n_res[OPND_WIDTH-1:0]} : n_x;
                        r_sh  <= {r_sh[OPND_WIDTH-2:0], n_res[ACC_WIDTH]};
                    end
                    OP_SQRT: begin
                        r_acc  <= n_res[ACC_WIDTH] ? n_res[ACC_WIDTH-1:0] : n_x;
                        r_sh   <= {r_sh[OPND_WIDTH-3:0], 2'b00};
                        r_root <= {r_root[OPND_WIDTH/2-2:0], n_res[ACC_WIDTH]};
                    end
                    OP_MUL: begin
                        r_acc <= {1'b0, n_res[ACC_WIDTH-1:1]};
                        r_sh  <= {r_sh[OPND_WIDTH-1:MUL_WIDTH], n_res[0],
                                  r_sh[MUL_WIDTH-1:1]};
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_sh;
    assign o_root     = r_root;
    assign o_product  = {r_acc[MUL_WIDTH-1:0], r_sh[MUL_WIDTH-1:0]};
endmodule

### hw/rtl/running_zscore_welford.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_zscore_welford
// Welford running mean and variance with a z-score for every sample.
// ----------------------------------------------------------------------------
// A signed Q16.16 sample arrives on i_sample; one result leaves on o_result
// for each sample: the z-score of the sample against the updated statistics,
// the sample standard deviation, the rounded running mean and the count.
// Each transfer updates count, mean and the sum of squared deviations.
// All arithmetic runs on one shared iterative unit: a 64-step divide for the
// mean step, a 50-step multiply for the squared-deviation increment, a
// 64-step divide and a 32-step square root for the deviation, and a 64-step
// divide for the z-score. A new sample is accepted only once the previous
// one has reached the output register. The first sample skips the variance
// divide and square root; a zero deviation skips the z-score divide.
// The result sits in an output register; the next sample is accepted while
// it waits, and only the final load stalls if the receiver is not ready.
// Synchronous reset clears count, mean and squared-deviation sum to zero.
// ----------------------------------------------------------------------------
module running_zscore_welford (
    input  logic        i_clk,
    input  logic        i_rst_n,
    zsw_sample_if.sink   i_sample,
    zsw_result_if.source o_result
);
    import zsw_pkg::*;

    localparam int ZSH_A = (FRAC_BITS >= MEAN_EXTRA) ? FRAC_BITS - MEAN_EXTRA : 0;
    localparam int ZSH_B = (FRAC_BITS >= MEAN_EXTRA) ? 0 : MEAN_EXTRA - FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MDIV,
        S_MUPD,
        S_MUL,
        S_VDIV,
        S_SQRT,
        S_ZSET,
        S_ZDIV,
        S_FIN
    } t_state;

    t_state                        r_state;
    logic [COUNT_WIDTH-1:0]        r_count;
    logic signed [MEAN_WIDTH-1:0]  r_mean;
    logic [M2_WIDTH-1:0]           r_m2;
    logic signed [MEAN_WIDTH-1:0]  r_vx;
    logic                          r_dneg;
    logic                          r_eneg;
    logic [OPND_WIDTH-1:0]         r_ad;
    logic [OPND_WIDTH-1:0]         r_ae;
    logic [DATA_WIDTH-1:0]         r_sd;
    logic [DATA_WIDTH-1:0]         r_zq;
    logic                          r_out_valid;
    logic signed [DATA_WIDTH-1:0]  r_out_z;
    logic [DATA_WIDTH-1:0]         r_out_sd;
    logic signed [DATA_WIDTH-1:0]  r_out_mu;
    logic [DATA_WIDTH-1:0]         r_out_n;

    t_unit_req                     n_req;
    logic [OPND_WIDTH-1:0]         n_opa;
    logic [OPND_WIDTH-1:0]         n_opb;
    logic                          u_done;
    logic [OPND_WIDTH-1:0]         u_quotient;
    logic [OPND_WIDTH/2-1:0]       u_root;
    logic [2*MUL_WIDTH-1:0]        u_product;

    logic                          n_accept;
    logic signed [MEAN_WIDTH-1:0]  n_vx;
    logic [COUNT_WIDTH-1:0]        n_count;
    logic signed [MEAN_WIDTH:0]    n_d;
    logic [OPND_WIDTH-1:0]         n_ad;
    logic signed [MEAN_WIDTH-1:0]  n_mean;
    logic signed [MEAN_WIDTH:0]    n_e;
    logic [OPND_WIDTH-1:0]         n_ae;
    logic                          n_mul_go;
    logic [M2_WIDTH-1:0]           n_inc;
    logic [M2_WIDTH:0]             n_m2sum;
    logic [M2_WIDTH-1:0]           n_m2;
    logic [OPND_WIDTH-1:0]         n_za;
    logic [OPND_WIDTH-1:0]         n_zb;
    logic [OPND_WIDTH-1:0]         n_mag;
    logic [DATA_WIDTH-1:0]         n_zq;
    logic signed [MEAN_WIDTH:0]    n_murnd;
    logic [63:0]                   n_cnt64;
    logic                          n_load;

    assign n_accept = i_sample.valid && i_sample.ready;
    assign n_vx     = MEAN_WIDTH'(i_sample.sample_value) <<< MEAN_EXTRA;
    assign n_count  = (&r_count) ? r_count : r_count + 1'b1;
    assign n_d      = (MEAN_WIDTH + 1)'(n_vx) - (MEAN_WIDTH + 1)'(r_mean);
    assign n_ad     = n_d[MEAN_WIDTH] ? OPND_WIDTH'(-n_d) : OPND_WIDTH'(n_d);

    assign n_mean   = r_dneg ? r_mean - MEAN_WIDTH'(u_quotient) :
                               r_mean + MEAN_WIDTH'(u_quotient);
    assign n_e      = (MEAN_WIDTH + 1)'(r_vx) - (MEAN_WIDTH + 1)'(r_mean);
    assign n_ae     = n_e[MEAN_WIDTH] ? OPND_WIDTH'(-n_e) : OPND_WIDTH'(n_e);
    assign n_mul_go = !((r_dneg != n_e[MEAN_WIDTH]) && (r_ad != '0) && (n_ae != '0));

    assign n_inc    = u_product[32 +: M2_WIDTH] + M2_WIDTH'(u_product[31]);
    assign n_m2sum  = {1'b0, r_m2} + {1'b0, n_inc};
    assign n_m2     = n_m2sum[M2_WIDTH] ? '1 : n_m2sum[M2_WIDTH-1:0];

    assign n_za     = r_ae << ZSH_A;
    assign n_zb     = OPND_WIDTH'(r_sd) << ZSH_B;
    assign n_mag    = u_quotient;
    always_comb begin
        if (r_eneg) begin
            n_zq = (n_mag > 64'h8000_0000) ? 32'h8000_0000 : DATA_WIDTH'(-n_mag);
        end else begin
            n_zq = (n_mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : n_mag[DATA_WIDTH-1:0];
        end
    end

    assign n_murnd  = (MEAN_WIDTH + 1)'(r_mean) + (MEAN_WIDTH + 1)'(1 <<< (MEAN_EXTRA - 1));
    assign n_cnt64  = 64'(r_count);
    assign n_load   = !r_out_valid || o_result.ready;

    always_comb begin
        n_req.start = 1'b0;
        n_req.op    = OP_DIV;
        n_opa       = '0;
        n_opb       = '0;
        case (r_state)
            S_IDLE: begin
                n_req.start = n_accept;
                n_opa       = n_ad + OPND_WIDTH'(n_count >> 1);
                n_opb       = OPND_WIDTH'(n_count);
            end
            S_MUPD: begin
                n_req.start = n_mul_go;
                n_req.op    = OP_MUL;
                n_opa       = r_ad;
                n_opb       = n_ae;
            end
            S_VDIV: begin
                n_req.start = 1'b0;
            end
            S_SQRT: begin
                n_req.start = 1'b0;
            end
            S_ZSET: begin
                n_req.start = (r_sd != '0);
                n_opa       = n_za + (n_zb >> 1);
                n_opb       = n_zb;
            end
            default: begin
                n_req.start = 1'b0;
            end
        endcase
        if (((r_state == S_MUL && u_done) || (r_state == S_MUPD && !n_mul_go))
                && r_count > COUNT_WIDTH'(1)) begin
            n_req.start = 1'b1;
            n_req.op    = OP_DIV;
            n_opa       = (r_state == S_MUL) ? n_m2 : r_m2;
            n_opb       = OPND_WIDTH'(r_count - 1'b1);
        end
        if (r_state == S_VDIV && u_done) begin
            n_req.start = 1'b1;
            n_req.op    = OP_SQRT;
            n_opa       = u_quotient;
        end
    end

    zsw_unit u_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (n_req),
        .i_opa      (n_opa),
        .i_opb      (n_opb),
        .o_done     (u_done),
        .o_quotient (u_quotient),
        .o_root     (u_root),
        .o_product  (u_product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mean      <= '0;
            r_m2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_vx    <= n_vx;
                        r_count <= n_count;
                        r_dneg  <= n_d[MEAN_WIDTH];
                        r_ad    <= n_ad;
                        r_state <= S_MDIV;
                    end
                end
                S_MDIV: begin
                    if (u_done) begin
                        r_mean  <= n_mean;
                        r_state <= S_MUPD;
                    end
                end
                S_MUPD: begin
                    r_eneg <= n_e[MEAN_WIDTH];
                    r_ae   <= n_ae;
                    if (n_mul_go) begin
                        r_state <= S_MUL;
                    end else if (r_count > COUNT_WIDTH'(1)) begin
                        r_state <= S_VDIV;
                        r_sd    <= '0;
                    end else begin
                        r_sd    <= DATA_WIDTH'(1) << FRAC_BITS;
                        r_state <= S_ZSET;
                    end
                end
                S_MUL: begin
                    if (u_done) begin
                        r_m2 <= n_m2;
                        if (r_count > COUNT_WIDTH'(1)) begin
                            r_state <= S_VDIV;
                        end else begin
                            r_sd    <= DATA_WIDTH'(1) << FRAC_BITS;
                            r_state <= S_ZSET;
                        end
                    end
                end
                S_VDIV: begin
                    if (u_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (u_done) begin
                        r_sd    <= u_root;
                        r_state <= S_ZSET;
                    end
                end
                S_ZSET: begin
                    r_zq    <= '0;
                    r_state <= (r_sd != '0) ? S_ZDIV : S_FIN;
                end
                S_ZDIV: begin
                    if (u_done) begin
                        r_zq    <= n_zq;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_load) begin
                        r_out_valid <= 1'b1;
                        r_out_z     <= r_zq;
                        r_out_sd    <= r_sd;
                        r_out_mu    <= n_murnd[MEAN_EXTRA +: DATA_WIDTH];
                        r_out_n     <= (n_cnt64 > 64'hFFFF_FFFF) ? '1 : n_cnt64[31:0];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_sample.ready        = (r_state == S_IDLE);
    assign o_result.valid        = r_out_valid;
    assign o_result.z_score      = r_out_z;
    assign o_result.deviation    = r_out_sd;
    assign o_result.mean_value   = r_out_mu;
    assign o_result.sample_total = r_out_n;
endmodule
